>>> rtl/core/ciss_pkg.sv
`timescale 1ns / 1ps

package ciss_pkg;

    // Character and pattern geometry fixed by the register map
    localparam int CHAR_W    = 8;
    localparam int PAT_CHARS = 16;
    localparam int LEN_W     = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 64;
    localparam int POS_OUT_W = 32;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LENGTH = 2'd0,
        CFG_PATTERN_LOW    = 2'd1,
        CFG_PATTERN_HIGH   = 2'd2
    } t_cfg_reg;

    // Data handed from one window cell to the next
    typedef struct packed {
        logic              valid;
        logic [CHAR_W-1:0] chr;
    } t_link;

    // Common control for all window cells
    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

    // Fold ASCII upper-case letters to lower case
    function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

>>> rtl/core/ciss_cell.sv
`timescale 1ns / 1ps

// One position of the text window. It holds one folded character and a flag
// that tells whether a character of the current text has reached it.
module ciss_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ciss_pkg::t_cell_ctl             i_ctl,
    input  ciss_pkg::t_link                 i_link,
    input  logic                            i_active,
    input  logic [ciss_pkg::CHAR_W-1:0]     i_pchar,
    output ciss_pkg::t_link                 o_link,
    output logic                            o_hit
);

    logic                        r_valid;
    logic [ciss_pkg::CHAR_W-1:0] r_chr;

    // The character arriving this beat is compared with its pattern character.
    assign o_hit = !i_active || (i_link.valid && (i_link.chr == i_pchar));

    // Fill flag: cleared at the end of a text, shifted along otherwise.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.clear) begin
            r_valid <= 1'b0;
        end else if (i_ctl.shift) begin
            r_valid <= i_link.valid;
        end
    end

    // Character payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_chr <= i_link.chr;
        end
    end

    assign o_link.valid = r_valid;
    assign o_link.chr   = r_chr;

endmodule

>>> rtl/core/case_insensitive_substring_search_unit.sv
`timescale 1ns / 1ps

// Case-insensitive substring search. Text arrives one byte per beat on the
// slave stream and a zero byte ends the text; one result beat follows each
// terminator, in the cycle after it is taken. The block takes one byte every
// clock: the window is a row of MAX_PATTERN cells that shift each byte along
// and compare all pattern characters at once in the same cycle. The input
// ready drops only when a terminator arrives while the previous result still
// waits to be taken; ordinary text bytes are always accepted. The pattern
// (length and up to 16 characters) is folded to lower case as written. The
// user writes it through the configuration port while the block is idle; the
// block does not enforce this. Positions are counted in POSITION_BITS bits; a
// longer text saturates the counter and sets the saturation flag in the result.
module case_insensitive_substring_search_unit #(
    parameter int MAX_PATTERN   = 16,
    parameter int POSITION_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Text stream
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [7:0]                         i_s_axis_tdata,  // [7:0] text_byte
    // Result stream
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [0] found, [32:1] match_position, [33] position_saturated, [39:34] zero
    output logic [39:0]                        o_m_axis_tdata,
    // Configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ciss_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ciss_pkg::CFG_W-1:0]         i_cfg_data
);

    localparam int CW = ciss_pkg::CHAR_W;

    // Configuration registers
    logic [ciss_pkg::LEN_W-1:0] r_len;
    logic [CW-1:0]              r_pat [ciss_pkg::PAT_CHARS];

    // Per-text state
    logic [POSITION_BITS-1:0]   r_cnt;
    logic                       r_sat;
    logic                       r_found;
    logic [POSITION_BITS-1:0]   r_start;

    // Result register
    logic                       r_ovalid;
    logic [39:0]                r_odata;

    logic                       w_accept;
    logic                       w_term;
    ciss_pkg::t_cell_ctl        w_ctl;
    ciss_pkg::t_link            w_in  [MAX_PATTERN];
    ciss_pkg::t_link            w_out [MAX_PATTERN];
    logic [MAX_PATTERN-1:0]     w_hit;
    logic                       w_len_ok;
    logic                       w_match;
    logic [POSITION_BITS+ciss_pkg::POS_OUT_W-1:0] w_pos_ext;
    logic [ciss_pkg::POS_OUT_W-1:0]               w_pos;
    logic                       w_res_found;

    assign o_cfg_ready = 1'b1;

    // Configuration writes; pattern characters are stored already folded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            for (int j = 0; j < ciss_pkg::PAT_CHARS; j++) begin
                r_pat[j] <= '0;
            end
        end else if (i_cfg_valid) begin
            unique case (ciss_pkg::t_cfg_reg'(i_cfg_index))
                ciss_pkg::CFG_PATTERN_LENGTH: begin
                    r_len <= i_cfg_data[ciss_pkg::LEN_W-1:0];
                end
                ciss_pkg::CFG_PATTERN_LOW: begin
                    for (int j = 0; j < ciss_pkg::PAT_CHARS / 2; j++) begin
                        r_pat[j] <= ciss_pkg::fold(i_cfg_data[j*CW +: CW]);
                    end
                end
                ciss_pkg::CFG_PATTERN_HIGH: begin
                    for (int j = 0; j < ciss_pkg::PAT_CHARS / 2; j++) begin
                        r_pat[j + ciss_pkg::PAT_CHARS / 2] <=
                            ciss_pkg::fold(i_cfg_data[j*CW +: CW]);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Input handshake: only a terminator has to wait for the result register.
    assign o_s_axis_tready = !r_ovalid || i_m_axis_tready || (i_s_axis_tdata != '0);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_term          = w_accept && (i_s_axis_tdata == '0);
    assign w_ctl.shift     = w_accept && (i_s_axis_tdata != '0);
    assign w_ctl.clear     = w_term;

    // Row of window cells; cell k compares the character of age k, age 0 being the arriving byte.
    assign w_in[0].valid = 1'b1;
    assign w_in[0].chr   = ciss_pkg::fold(i_s_axis_tdata);

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        logic                             w_active;
        logic [ciss_pkg::LEN_W-1:0]       w_idx;

        if (k > 0) begin : g_link
            assign w_in[k] = w_out[k-1];
        end

        // Cell k meets pattern character len-1-k while k is below len.
        assign w_active = (k < int'(r_len));
        assign w_idx    = r_len - ciss_pkg::LEN_W'(k) - ciss_pkg::LEN_W'(1);

        ciss_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_link   (w_in[k]),
            .i_active (w_active),
            .i_pchar  (r_pat[w_idx[3:0]]),
            .o_link   (w_out[k]),
            .o_hit    (w_hit[k])
        );
    end

    // A length beyond the window or the pattern registers never matches.
    assign w_len_ok = (r_len != '0) && (int'(r_len) <= MAX_PATTERN)
                      && (int'(r_len) <= ciss_pkg::PAT_CHARS);
    assign w_match  = w_len_ok && (&w_hit);

    // Position counter, saturation flag and first match start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_sat   <= 1'b0;
            r_found <= 1'b0;
            r_start <= '0;
        end else if (w_term) begin
            r_cnt   <= '0;
            r_sat   <= 1'b0;
            r_found <= 1'b0;
            r_start <= '0;
        end else if (w_ctl.shift) begin
            if (r_cnt != '1) begin
                r_cnt <= r_cnt + POSITION_BITS'(1);
            end else begin
                r_sat <= 1'b1;
            end
            if (!r_found && w_match) begin
                r_found <= 1'b1;
                r_start <= r_cnt - POSITION_BITS'(r_len - ciss_pkg::LEN_W'(1));
            end
        end
    end

    // Result fields; an empty pattern matches at the start.
    assign w_pos_ext   = {{ciss_pkg::POS_OUT_W{1'b0}}, r_start};
    assign w_res_found = (r_len == '0) || r_found;
    assign w_pos       = (r_len == '0) ? '0 : w_pos_ext[ciss_pkg::POS_OUT_W-1:0];

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_term) begin
            r_ovalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_term) begin
            r_odata <= {6'b0, r_sat, w_pos, w_res_found};
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

endmodule

>>> rtl/core/ciss_checker.sv
`timescale 1ns / 1ps

// Port-level checks for the search unit.
module ciss_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        i_s_tready,
    input logic [7:0]  i_s_tdata,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [39:0] i_m_tdata
);

    // A taken terminator yields a result beat in the next cycle.
    a_term_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && i_s_tready && (i_s_tdata == 8'h00)) |=> i_m_tvalid)
        else $error("no result after terminator");

    // A result that was not found reports position zero.
    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tdata[0]) |-> (i_m_tdata[32:1] == 32'h0))
        else $error("nonzero position without a match");

    // A new result beat only follows a taken terminator.
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_m_tvalid) |-> $past(i_s_tvalid && i_s_tready && (i_s_tdata == 8'h00)))
        else $error("result beat without terminator");

    // A stalled result beat holds its data.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |=> (i_m_tvalid && $stable(i_m_tdata)))
        else $error("stalled result changed");

endmodule

bind case_insensitive_substring_search_unit ciss_checker u_ciss_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_axis_tvalid),
    .i_s_tready (o_s_axis_tready),
    .i_s_tdata  (i_s_axis_tdata),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata)
);
